[sv/rgbyuv_pkg.sv]
// Package for the RGB24 to YUYV converter: shared widths, the pixel and
// pair item types, and the conversion coefficients. No dependencies.
`timescale 1ns / 1ps

package rgbyuv_pkg;

    // Largest row the column counter has to cover
    localparam int MAX_WIDTH   = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_WIDTH_W = 13;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd640;

    // Luma coefficients
    localparam logic [16:0] KY_R = 17'd66;
    localparam logic [16:0] KY_G = 17'd129;
    localparam logic [16:0] KY_B = 17'd25;
    localparam logic [16:0] Y_ROUND = 17'd128;
    localparam logic [7:0]  Y_OFFSET = 8'd16;

    // Chroma coefficients (magnitudes; signs applied in the datapath)
    localparam logic signed [17:0] KU_R = 18'sd38;
    localparam logic signed [17:0] KU_G = 18'sd74;
    localparam logic signed [17:0] KU_B = 18'sd112;
    localparam logic signed [17:0] KV_R = 18'sd112;
    localparam logic signed [17:0] KV_G = 18'sd94;
    localparam logic signed [17:0] KV_B = 18'sd18;
    localparam logic signed [17:0] C_ROUND = 18'sd256;
    localparam logic [7:0]         C_OFFSET = 8'd128;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // One macropixel job: a lone tail pixel is sent with both halves equal
    typedef struct packed {
        pixel_t first;
        pixel_t second;
        logic   end_of_row;
    } pair_item_t;

endpackage

[sv/rgbyuv_front.sv]
// Front end of the converter: takes pixels, tracks the row position, holds
// the first pixel of each pair and issues pair jobs. Uses rgbyuv_pkg.
`timescale 1ns / 1ps

module rgbyuv_front (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rgbyuv_pkg::ROW_WIDTH_W-1:0]  cfg_data,
    // incoming pixels
    input  logic                                pix_valid,
    output logic                                pix_ready,
    input  rgbyuv_pkg::pixel_t                  pix,
    // pair jobs toward the queue
    output logic                                job_valid,
    input  logic                                job_ready,
    output rgbyuv_pkg::pair_item_t              job
);
    import rgbyuv_pkg::*;

    logic [ROW_WIDTH_W-1:0] row_width_reg;
    pixel_t                 held_reg, held_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic                   half_reg, half_next;
    logic [COL_W-1:0]       last_col;
    logic                   at_last;
    logic                   take;

    assign cfg_ready = 1'b1;

    // Row width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            row_width_reg <= cfg_data;
        end
    end

    // Last column: zero width acts as one, oversize clamps to the maximum
    always_comb
    begin
        if (row_width_reg == '0)
        begin
            last_col = '0;
        end
        else if (row_width_reg > ROW_WIDTH_W'(MAX_WIDTH))
        begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = COL_W'(row_width_reg - 1'b1);
        end
    end

    assign at_last   = (col_reg >= last_col);
    assign pix_ready = job_ready;
    assign take      = pix_valid && pix_ready;

    // Classify the pixel: held first half, lone tail, or pair completion
    always_comb
    begin
        held_next  = held_reg;
        col_next   = col_reg;
        half_next  = half_reg;
        job_valid  = 1'b0;
        job.first  = held_reg;
        job.second = pix;
        job.end_of_row = at_last;
        if (take)
        begin
            if (!half_reg)
            begin
                if (at_last)
                begin
                    job_valid = 1'b1;
                    job.first = pix;
                    col_next  = '0;
                end
                else
                begin
                    held_next = pix;
                    half_next = 1'b1;
                    col_next  = col_reg + 1'b1;
                end
            end
            else
            begin
                job_valid = 1'b1;
                half_next = 1'b0;
                col_next  = at_last ? '0 : col_reg + 1'b1;
            end
        end
    end

    // Position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            col_reg  <= '0;
            half_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            col_reg  <= col_next;
            half_reg <= half_next;
        end
    end

endmodule

[sv/rgbyuv_queue.sv]
// Two-entry queue of pair jobs between the front end and the datapath.
// Uses rgbyuv_pkg for the job type.
`timescale 1ns / 1ps

module rgbyuv_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_valid,
    output logic                    wr_ready,
    input  rgbyuv_pkg::pair_item_t  wr_item,
    output logic                    rd_valid,
    input  logic                    rd_ready,
    output rgbyuv_pkg::pair_item_t  rd_item
);
    import rgbyuv_pkg::*;

    pair_item_t  slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[sv/rgbyuv_back.sv]
// Datapath of the converter: two register stages that turn a pair job into
// a YUYV macropixel, the second being the output register. Uses rgbyuv_pkg.
`timescale 1ns / 1ps

module rgbyuv_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_valid,
    output logic                    job_ready,
    input  rgbyuv_pkg::pair_item_t  job,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              y_first,
    output logic [7:0]              u_chroma,
    output logic [7:0]              y_second,
    output logic [7:0]              v_chroma,
    output logic                    end_of_row
);
    import rgbyuv_pkg::*;

    // stage 1: weighted sums
    logic                s1_valid_reg;
    logic [16:0]         y0_sum_reg, y1_sum_reg;
    logic signed [17:0]  u_sum_reg, v_sum_reg;
    logic                s1_eor_reg;
    // stage 2: output register
    logic                s2_valid_reg;
    logic [7:0]          y0_reg, y1_reg, u_reg, v_reg;
    logic                s2_eor_reg;

    logic                s1_en, s2_en;
    logic [8:0]          rs, gs, bs;
    logic signed [17:0]  rs_s, gs_s, bs_s;
    logic signed [17:0]  u_sum_next, v_sum_next;
    logic [16:0]         y0_sum_next, y1_sum_next;
    logic signed [17:0]  u_shift, v_shift;

    assign s2_en     = !s2_valid_reg || out_ready;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign job_ready = s1_en;

    // Pair sums and weighted terms
    always_comb
    begin
        rs = {1'b0, job.first.red}   + {1'b0, job.second.red};
        gs = {1'b0, job.first.green} + {1'b0, job.second.green};
        bs = {1'b0, job.first.blue}  + {1'b0, job.second.blue};
        rs_s = $signed({9'd0, rs});
        gs_s = $signed({9'd0, gs});
        bs_s = $signed({9'd0, bs});
        u_sum_next = KU_B * bs_s - KU_R * rs_s - KU_G * gs_s;
        v_sum_next = KV_R * rs_s - KV_G * gs_s - KV_B * bs_s;
        y0_sum_next = KY_R * {9'd0, job.first.red} + KY_G * {9'd0, job.first.green}
                    + KY_B * {9'd0, job.first.blue};
        y1_sum_next = KY_R * {9'd0, job.second.red} + KY_G * {9'd0, job.second.green}
                    + KY_B * {9'd0, job.second.blue};
    end

    // Rounding shifts for chroma (floor shift of the pair sum)
    assign u_shift = (u_sum_reg + C_ROUND) >>> 9;
    assign v_shift = (v_sum_reg + C_ROUND) >>> 9;

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= job_valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            y0_sum_reg <= y0_sum_next;
            y1_sum_reg <= y1_sum_next;
            u_sum_reg  <= u_sum_next;
            v_sum_reg  <= v_sum_next;
            s1_eor_reg <= job.end_of_row;
        end
        if (s2_en)
        begin
            y0_reg     <= 8'((y0_sum_reg + Y_ROUND) >> 8) + Y_OFFSET;
            y1_reg     <= 8'((y1_sum_reg + Y_ROUND) >> 8) + Y_OFFSET;
            u_reg      <= u_shift[7:0] + C_OFFSET;
            v_reg      <= v_shift[7:0] + C_OFFSET;
            s2_eor_reg <= s1_eor_reg;
        end
    end

    assign out_valid  = s2_valid_reg;
    assign y_first    = y0_reg;
    assign u_chroma   = u_reg;
    assign y_second   = y1_reg;
    assign v_chroma   = v_reg;
    assign end_of_row = s2_eor_reg;

endmodule

[sv/rgb24_to_yuyv_converter.sv]
// Top level of the RGB24 to YUYV 4:2:2 converter: front end, job queue and
// datapath. Depends on rgbyuv_pkg, rgbyuv_front, rgbyuv_queue, rgbyuv_back.
`timescale 1ns / 1ps

// Converts a raster stream of 8-bit RGB pixels into BT.601 studio-range
// YUYV macropixels, one macropixel per pixel pair; an odd row's last pixel
// comes out alone with its luma duplicated, and tlast marks the last
// macropixel of each row. The block takes one pixel per clock while the
// queue has room: a pixel is classified in the cycle it is accepted, and a
// finished pair goes into a two-entry queue and then through two datapath
// registers (weighted sums, then output). row_width must be written through
// the cfg channel (always ready) only while the stream is idle, which the
// block does not enforce; 0 acts as 1 and values above 4096 act as 4096.
module rgb24_to_yuyv_converter (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: row_width
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    // macropixel output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // y_first, u_chroma, y_second, v_chroma
    output logic        m_tlast    // end_of_row
);
    import rgbyuv_pkg::*;

    pixel_t     pix;
    pair_item_t front_job;
    pair_item_t queue_job;
    logic       front_valid, front_ready;
    logic       queue_valid, queue_ready;

    assign pix.red   = s_tdata[7:0];
    assign pix.green = s_tdata[15:8];
    assign pix.blue  = s_tdata[23:16];

    rgbyuv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .pix_valid (s_tvalid),
        .pix_ready (s_tready),
        .pix       (pix),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    rgbyuv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_item  (front_job),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_item  (queue_job)
    );

    rgbyuv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (queue_valid),
        .job_ready  (queue_ready),
        .job        (queue_job),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .y_first    (m_tdata[7:0]),
        .u_chroma   (m_tdata[15:8]),
        .y_second   (m_tdata[23:16]),
        .v_chroma   (m_tdata[31:24]),
        .end_of_row (m_tlast)
    );

endmodule

[sv/rgbyuv_checker.sv]
// Port-level checks for the RGB24 to YUYV converter, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module rgbyuv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // A stalled item stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    // A stalled item keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // Every component lands between 16 and 240 (the chroma studio range)
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            m_tdata[7:0]   >= 8'd16 && m_tdata[7:0]   <= 8'd240 &&
            m_tdata[15:8]  >= 8'd16 && m_tdata[15:8]  <= 8'd240 &&
            m_tdata[23:16] >= 8'd16 && m_tdata[23:16] <= 8'd240 &&
            m_tdata[31:24] >= 8'd16 && m_tdata[31:24] <= 8'd240)
        else $error("output component outside studio range");

endmodule

bind rgb24_to_yuyv_converter rgbyuv_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
